### rtl/bha_pkg.sv
// shared types and constants of the block handle allocator
package bha_pkg;

  // pool size and derived widths
  localparam int NUM_BLOCKS = 256;
  localparam int HND_W      = 9;
  localparam int IDX_W      = $clog2(NUM_BLOCKS);

  // request kinds
  localparam logic [1:0] KIND_ALLOC    = 2'd0;
  localparam logic [1:0] KIND_FREE     = 2'd1;
  localparam logic [1:0] KIND_FREE_ALL = 2'd2;

  // result status codes
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_BAD   = 2'd2;

  typedef struct packed {
    logic [1:0]       kind;
    logic [HND_W-1:0] handle;
  } bha_in_t;

  typedef struct packed {
    logic [HND_W-1:0] given_handle;
    logic [1:0]       status;
    logic [HND_W-1:0] free_blocks;
    logic [HND_W-1:0] used_blocks;
  } bha_out_t;

  // one write port of a link memory
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] addr;
    logic [HND_W-1:0] data;
  } link_wr_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_A_LINK,
    S_F_UNLINK,
    S_F_PUSH,
    S_RESP
  } state_t;

endpackage

### rtl/bha_link_ram.sv
// link memory: one write port, one registered read port
module bha_link_ram import bha_pkg::*; (
  input  logic             clk,
  input  link_wr_t         wr,
  input  logic [IDX_W-1:0] raddr,
  output logic [HND_W-1:0] rdata
);

  logic [HND_W-1:0] mem [NUM_BLOCKS];
  logic [HND_W-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/block_handle_allocator_top.sv
// top level of the block handle allocator: sequencer, list heads and link memories
//
//  channel | ports                          | direction | payload
//  --------+--------------------------------+-----------+-----------
//  request | in_valid, in_stall, in_data    | in        | bha_in_t
//  result  | out_valid, out_stall, out_data | out       | bha_out_t
//
// allocate runs S_EXEC, S_A_LINK, S_RESP; free of a handle in use runs S_EXEC,
// S_F_UNLINK, S_F_PUSH, S_RESP; free-all, bad free, empty pool, unknown kind run
// S_EXEC, S_RESP, as each link memory has one write port and a registered read.
// reset clears list heads, counts and next-link valid bits at once; in-use flags sit
// in a small memory and count only where the valid bit is set, so no clearing pass.
// the result sits in an output register; under out_stall it holds, and the next
// request is accepted once the result has been loaded into that register.
module block_handle_allocator_top import bha_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  bha_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output bha_out_t out_data
);

  // handle to memory index
  function automatic logic [IDX_W-1:0] h2idx(input logic [HND_W-1:0] h);
    logic [HND_W-1:0] d;
    d = h - HND_W'(1);
    return d[IDX_W-1:0];
  endfunction

  // next link of an entry never written since reset or free-all
  function automatic logic [HND_W-1:0] dflt_next(input logic [HND_W-1:0] h);
    logic [HND_W-1:0] r;
    if (h == HND_W'(NUM_BLOCKS)) r = '0;
    else                         r = h + HND_W'(1);
    return r;
  endfunction

  state_t state_r, state_nxt;

  bha_in_t          req_r, req_nxt;
  logic [HND_W-1:0] lnk_h_r, lnk_h_nxt;
  logic [HND_W-1:0] free_head_r, free_head_nxt;
  logic [HND_W-1:0] used_head_r, used_head_nxt;
  logic [HND_W-1:0] used_tail_r, used_tail_nxt;
  logic [HND_W-1:0] free_total_r, free_total_nxt;
  logic [HND_W-1:0] used_total_r, used_total_nxt;
  logic [HND_W-1:0] given_r, given_nxt;
  logic [1:0]       status_r, status_nxt;
  logic [NUM_BLOCKS-1:0] nval_r, nval_nxt;
  logic             nval_q_r, nval_q_nxt;
  logic             out_valid_r, out_valid_nxt;
  bha_out_t         out_data_r, out_data_nxt;

  logic             use_mem [NUM_BLOCKS];
  logic             use_q_r;
  logic             use_we;
  logic [IDX_W-1:0] use_waddr;
  logic             use_wdata;

  link_wr_t         prev_wr, next_wr;
  logic [IDX_W-1:0] prev_raddr, next_raddr;
  logic [HND_W-1:0] prev_q, next_q;

  logic             in_acc;
  logic             req_bad;
  logic             pool_empty;
  logic             resp_load;
  logic [HND_W-1:0] next_val;
  logic [HND_W-1:0] unl_p;

  // link memories
  bha_link_ram u_prev (
    .clk   (clk),
    .wr    (prev_wr),
    .raddr (prev_raddr),
    .rdata (prev_q)
  );

  bha_link_ram u_next (
    .clk   (clk),
    .wr    (next_wr),
    .raddr (next_raddr),
    .rdata (next_q)
  );

  // in-use flags, read at the accepting edge so the flag is ready in S_EXEC
  always_ff @(posedge clk) begin
    if (use_we) begin
      use_mem[use_waddr] <= use_wdata;
    end
    use_q_r <= use_mem[h2idx(in_data.handle)];
  end

  // request decode
  assign in_stall   = (state_r != S_IDLE);
  assign in_acc     = in_valid && !in_stall;
  assign req_bad    = (req_r.handle == '0) || (req_r.handle > HND_W'(NUM_BLOCKS)) ||
                      !(nval_r[h2idx(req_r.handle)] && use_q_r);
  assign pool_empty = (free_total_r == '0) || (free_head_r == '0);
  assign resp_load  = (state_r == S_RESP) && (!out_valid_r || !out_stall);

  // link values read in the previous cycle
  assign next_val = nval_q_r ? next_q : dflt_next(lnk_h_r);
  assign unl_p    = (lnk_h_r == used_head_r) ? '0 : prev_q;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        unique case (req_r.kind)
          KIND_ALLOC: state_nxt = pool_empty ? S_RESP : S_A_LINK;
          KIND_FREE:  state_nxt = req_bad ? S_RESP : S_F_UNLINK;
          default:    state_nxt = S_RESP;
        endcase
      end
      S_A_LINK:   state_nxt = S_RESP;
      S_F_UNLINK: state_nxt = S_F_PUSH;
      S_F_PUSH:   state_nxt = S_RESP;
      S_RESP: begin
        if (resp_load) state_nxt = S_IDLE;
      end
      default:    state_nxt = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    req_nxt        = req_r;
    lnk_h_nxt      = lnk_h_r;
    free_head_nxt  = free_head_r;
    used_head_nxt  = used_head_r;
    used_tail_nxt  = used_tail_r;
    free_total_nxt = free_total_r;
    used_total_nxt = used_total_r;
    given_nxt      = given_r;
    status_nxt     = status_r;
    nval_nxt       = nval_r;
    nval_q_nxt     = nval_q_r;
    out_data_nxt   = out_data_r;
    out_valid_nxt  = out_valid_r && out_stall;
    prev_wr        = '0;
    next_wr        = '0;
    prev_raddr     = h2idx(req_r.handle);
    next_raddr     = h2idx(req_r.handle);
    use_we         = 1'b0;
    use_waddr      = h2idx(lnk_h_r);
    use_wdata      = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) req_nxt = in_data;
      end
      S_EXEC: begin
        given_nxt  = '0;
        status_nxt = ST_DONE;
        unique case (req_r.kind)
          KIND_ALLOC: begin
            if (pool_empty) begin
              status_nxt = ST_EMPTY;
            end else begin
              // fetch the free-list successor of the head
              next_raddr = h2idx(free_head_r);
              nval_q_nxt = nval_r[h2idx(free_head_r)];
              lnk_h_nxt  = free_head_r;
            end
          end
          KIND_FREE: begin
            if (req_bad) begin
              status_nxt = ST_BAD;
            end else begin
              // fetch both neighbors of the handle
              nval_q_nxt = nval_r[h2idx(req_r.handle)];
              lnk_h_nxt  = req_r.handle;
            end
          end
          KIND_FREE_ALL: begin
            // ascending free list comes back from the valid bits
            nval_nxt       = '0;
            free_head_nxt  = HND_W'(1);
            used_head_nxt  = '0;
            used_tail_nxt  = '0;
            free_total_nxt = HND_W'(NUM_BLOCKS);
            used_total_nxt = '0;
          end
          default: begin
          end
        endcase
      end
      S_A_LINK: begin
        // pop free head, push onto used front
        free_head_nxt            = next_val;
        free_total_nxt           = free_total_r - HND_W'(1);
        used_total_nxt           = used_total_r + HND_W'(1);
        use_we                   = 1'b1;
        use_wdata                = 1'b1;
        nval_nxt[h2idx(lnk_h_r)]   = 1'b1;
        next_wr                  = '{we: 1'b1, addr: h2idx(lnk_h_r), data: used_head_r};
        if (used_head_r == '0) begin
          used_tail_nxt = lnk_h_r;
        end else begin
          prev_wr = '{we: 1'b1, addr: h2idx(used_head_r), data: lnk_h_r};
        end
        used_head_nxt = lnk_h_r;
        given_nxt     = lnk_h_r;
      end
      S_F_UNLINK: begin
        // unlink from the used list
        if (lnk_h_r == used_head_r) begin
          used_head_nxt = next_val;
        end else begin
          next_wr              = '{we: 1'b1, addr: h2idx(unl_p), data: next_val};
          nval_nxt[h2idx(unl_p)] = 1'b1;
        end
        if (lnk_h_r == used_tail_r) begin
          used_tail_nxt = unl_p;
        end else begin
          prev_wr = '{we: 1'b1, addr: h2idx(next_val), data: unl_p};
        end
      end
      S_F_PUSH: begin
        // push onto the free-list front
        next_wr                  = '{we: 1'b1, addr: h2idx(lnk_h_r), data: free_head_r};
        nval_nxt[h2idx(lnk_h_r)]   = 1'b1;
        use_we                   = 1'b1;
        use_wdata                = 1'b0;
        free_head_nxt            = lnk_h_r;
        free_total_nxt           = free_total_r + HND_W'(1);
        used_total_nxt           = used_total_r - HND_W'(1);
      end
      S_RESP: begin
        if (resp_load) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{given_handle: given_r, status: status_r,
                            free_blocks: free_total_r, used_blocks: used_total_r};
        end
      end
      default: begin
      end
    endcase
  end

  // control and list state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      free_head_r  <= HND_W'(1);
      used_head_r  <= '0;
      used_tail_r  <= '0;
      free_total_r <= HND_W'(NUM_BLOCKS);
      used_total_r <= '0;
      nval_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      free_head_r  <= free_head_nxt;
      used_head_r  <= used_head_nxt;
      used_tail_r  <= used_tail_nxt;
      free_total_r <= free_total_nxt;
      used_total_r <= used_total_nxt;
      nval_r       <= nval_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    lnk_h_r    <= lnk_h_nxt;
    given_r    <= given_nxt;
    status_r   <= status_nxt;
    nval_q_r   <= nval_q_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // every block is on exactly one list
  a_total: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, free_total_r} + {1'b0, used_total_r}) == (HND_W + 1)'(NUM_BLOCKS))
    else $error("free and used counts do not add up to the pool size");

  // free list empty exactly when its head is none
  a_free_head: assert property (@(posedge clk) disable iff (!rst_n)
    (free_head_r == '0) == (free_total_r == '0))
    else $error("free head disagrees with free count");

  // used list empty implies its head and tail are none
  a_used_head: assert property (@(posedge clk) disable iff (!rst_n)
    (used_total_r == '0) |-> (used_head_r == '0 && used_tail_r == '0))
    else $error("used list pointers set while used count is zero");

  // only a completed allocate hands out a handle
  a_given: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.given_handle == '0 || out_data_r.status == ST_DONE))
    else $error("handle given with a failing status");

  // an accepted transaction holds off the next one
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> in_stall)
    else $error("request accepted while busy");

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 100ps
// self-checking testbench of the block handle allocator: directed table, then random traffic
module testbench;
  import bha_pkg::*;

  // request kind outside the defined set, answered as a no-op
  localparam logic [1:0]       KIND_UNKNOWN   = 2'd3;
  localparam int               HND_MAX        = (1 << HND_W) - 1;
  localparam int               RANDOM_ITEMS   = 690;
  localparam int               GAP_PCT        = 11;
  localparam int               HOLD_CYCLES    = 80;
  localparam int               SETTLE_CYCLES  = 20;
  localparam int               WATCHDOG_LIMIT = 2000;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  bha_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  bha_out_t out_data;

  block_handle_allocator_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // one row of the directed table
  typedef struct {
    bha_in_t  req;
    bit       typed;
    bha_out_t want;
  } opening_row_t;

  opening_row_t opening_rows[$];

  // allocator image: free list as a stack with its head at the front, plus in-use flags
  int       free_stack[$];
  bit       pool_busy [0:NUM_BLOCKS];
  int       busy_count;
  bha_out_t expected_results[$];
  bha_out_t oldest_result;

  bit gaps_on        = 1'b1;
  bit hold_results   = 1'b0;
  bit hold_done      = 1'b0;
  int error_count    = 0;
  int sent_count     = 0;
  int checked_count  = 0;
  int empty_count    = 0;
  int bad_free_count = 0;
  int quiet_cycles   = 0;

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // free list back to ascending order, nothing in use
  function automatic void rebuild_pool();
    free_stack.delete();
    pool_busy[0] = 1'b0;
    for (int h = 1; h <= NUM_BLOCKS; h++) begin
      free_stack.push_back(h);
      pool_busy[h] = 1'b0;
    end
    busy_count = 0;
  endfunction

  // apply one request to the image and return the answer it earns
  function automatic bha_out_t allocator_step(input bha_in_t req);
    bha_out_t res;
    int       h;
    res        = '0;
    res.status = ST_DONE;
    h          = int'(req.handle);
    case (req.kind)
      KIND_ALLOC: begin
        if (free_stack.size() == 0) begin
          res.status = ST_EMPTY;
          empty_count++;
        end else begin
          h = free_stack.pop_front();
          pool_busy[h] = 1'b1;
          busy_count++;
          res.given_handle = HND_W'(h);
        end
      end
      KIND_FREE: begin
        if (h == 0 || h > NUM_BLOCKS || !pool_busy[h]) begin
          res.status = ST_BAD;
          bad_free_count++;
        end else begin
          pool_busy[h] = 1'b0;
          busy_count--;
          free_stack.push_front(h);
        end
      end
      KIND_FREE_ALL: rebuild_pool();
      default: ;
    endcase
    res.free_blocks = HND_W'(free_stack.size());
    res.used_blocks = HND_W'(busy_count);
    return res;
  endfunction

  // some handle now in use, searched from a random start
  function automatic logic [HND_W-1:0] pick_busy_handle();
    int start;
    int h;
    start = $urandom_range(NUM_BLOCKS - 1);
    for (int k = 0; k < NUM_BLOCKS; k++) begin
      h = (start + k) % NUM_BLOCKS + 1;
      if (pool_busy[h]) return HND_W'(h);
    end
    return '0;
  endfunction

  // random request; alloc_pct sets the share of allocates
  function automatic bha_in_t random_request(input int unsigned alloc_pct);
    bha_in_t     r;
    int unsigned roll;
    roll     = $urandom_range(99);
    r.handle = HND_W'($urandom_range(HND_MAX));
    if (roll < alloc_pct) begin
      r.kind = KIND_ALLOC;
    end else if (roll < 92) begin
      r.kind = KIND_FREE;
      if (busy_count != 0) r.handle = pick_busy_handle();
    end else if (roll < 97) begin
      r.kind = KIND_FREE;
    end else if (roll < 99) begin
      r.kind = KIND_UNKNOWN;
    end else begin
      r.kind = KIND_FREE_ALL;
    end
    return r;
  endfunction

  task automatic plan_row(input logic [1:0] kind, input int handle, input bit typed,
                          input int given, input logic [1:0] status, input int free_n,
                          input int used_n);
    opening_row_t row;
    row.req.kind          = kind;
    row.req.handle        = HND_W'(handle);
    row.typed             = typed;
    row.want.given_handle = HND_W'(given);
    row.want.status       = status;
    row.want.free_blocks  = HND_W'(free_n);
    row.want.used_blocks  = HND_W'(used_n);
    opening_rows.push_back(row);
  endtask

  // offer one transaction, predict it when accepted; called and returns at a falling edge
  task automatic send_request(input bha_in_t req, input bit typed, input bha_out_t want);
    bha_out_t predicted;
    while (gaps_on && $urandom_range(99) < GAP_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = allocator_step(req);
    expected_results.push_back(typed ? want : predicted);
    sent_count++;
    @(negedge clk);
  endtask

  // stop offering until every expected result is back
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (expected_results.size() != 0) @(negedge clk);
  endtask

  task automatic check_field(input string name, input logic [HND_W-1:0] want,
                             input logic [HND_W-1:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      error_count++;
    end
  endtask

  // result channel: random stalls, plus one long hold-off on request
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_results && !hold_done) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end
      out_stall <= gaps_on && ($urandom_range(99) < GAP_PCT);
    end
  end

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $display("%0t ns: result with nothing outstanding, expected none, got %p",
                 $time, out_data);
        error_count++;
      end else begin
        oldest_result = expected_results.pop_front();
        check_field("given_handle", oldest_result.given_handle, out_data.given_handle);
        check_field("status", HND_W'(oldest_result.status), HND_W'(out_data.status));
        check_field("free_blocks", oldest_result.free_blocks, out_data.free_blocks);
        check_field("used_blocks", oldest_result.used_blocks, out_data.used_blocks);
        checked_count++;
      end
    end
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t ns: no transaction for %0d cycles, %0d results outstanding",
               $time, WATCHDOG_LIMIT, expected_results.size());
      $display("testbench: done, errors");
      $finish;
    end
  end

  // stimulus
  initial begin
    bha_out_t    none;
    int unsigned alloc_pct;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    none     = '0;
    rebuild_pool();

    // directed table
    plan_row(KIND_ALLOC, 0, 1, 1, ST_DONE, NUM_BLOCKS - 1, 1);
    plan_row(KIND_ALLOC, HND_MAX, 1, 2, ST_DONE, NUM_BLOCKS - 2, 2);
    plan_row(KIND_FREE, 0, 1, 0, ST_BAD, NUM_BLOCKS - 2, 2);
    plan_row(KIND_FREE, NUM_BLOCKS + 1, 1, 0, ST_BAD, NUM_BLOCKS - 2, 2);
    plan_row(KIND_FREE, HND_MAX, 1, 0, ST_BAD, NUM_BLOCKS - 2, 2);
    plan_row(KIND_FREE, NUM_BLOCKS, 1, 0, ST_BAD, NUM_BLOCKS - 2, 2);
    // tail of the in-use list, then it comes back first
    plan_row(KIND_FREE, 1, 1, 0, ST_DONE, NUM_BLOCKS - 1, 1);
    plan_row(KIND_ALLOC, 0, 1, 1, ST_DONE, NUM_BLOCKS - 2, 2);
    plan_row(KIND_UNKNOWN, HND_MAX, 1, 0, ST_DONE, NUM_BLOCKS - 2, 2);
    // middle, head and last entry of the in-use list
    plan_row(KIND_ALLOC, HND_MAX, 0, 0, ST_DONE, 0, 0);
    plan_row(KIND_FREE, 1, 0, 0, ST_DONE, 0, 0);
    plan_row(KIND_FREE, 3, 0, 0, ST_DONE, 0, 0);
    plan_row(KIND_FREE, 2, 0, 0, ST_DONE, 0, 0);
    plan_row(KIND_FREE, 2, 1, 0, ST_BAD, NUM_BLOCKS, 0);
    repeat (3) plan_row(KIND_ALLOC, 0, 0, 0, ST_DONE, 0, 0);
    plan_row(KIND_FREE_ALL, HND_MAX, 1, 0, ST_DONE, NUM_BLOCKS, 0);
    plan_row(KIND_ALLOC, 0, 1, 1, ST_DONE, NUM_BLOCKS - 1, 1);
    plan_row(KIND_FREE_ALL, 0, 1, 0, ST_DONE, NUM_BLOCKS, 0);
    plan_row(KIND_FREE_ALL, 0, 1, 0, ST_DONE, NUM_BLOCKS, 0);
    plan_row(KIND_UNKNOWN, 0, 1, 0, ST_DONE, NUM_BLOCKS, 0);
    plan_row(KIND_FREE, 1, 1, 0, ST_BAD, NUM_BLOCKS, 0);

    // reset
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (opening_rows[r]) begin
      send_request(opening_rows[r].req, opening_rows[r].typed, opening_rows[r].want);
    end
    wait_for_results();

    // random traffic: mixed, pool fill past empty, drain-heavy, mixed
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 150) wait_for_results();
      if (i == 500) hold_results = 1'b1;
      gaps_on   = !(i >= 300 && i < 400);
      alloc_pct = (i < 150) ? 55 : (i < 420) ? 100 : (i < 600) ? 20 : 55;
      send_request(random_request(alloc_pct), 1'b0, none);
    end
    gaps_on = 1'b1;
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("run: %0d requests, %0d results checked, %0d on an empty pool, %0d bad frees",
             sent_count, checked_count, empty_count, bad_free_count);
    $display("run: directed corners, pool filled past empty, long result hold-off, no-gap span");
    if (error_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
